FILE: design/fbr_pkg.sv
// fbr_pkg: sizes, entry layout, register indexes and reset values shared by the
// frequency-based replacement tag store and its testbench
// no dependencies
package fbr_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int SLOTS       = MAX_ENTRIES + 1;
  localparam int ADDR_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam int FILE_W    = 16;
  localparam int OFF_W     = 32;
  localparam int REFS_W    = 16;
  localparam int HIT_POS_W = 6;

  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  localparam int IN_BITS     = FILE_W + OFF_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + HIT_POS_W + 1 + FILE_W + OFF_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_START = 2'd2;

  localparam logic [CFG_W-1:0] CAPACITY_RST  = 7'd64;
  localparam logic [CFG_W-1:0] NEW_SIZE_RST  = 7'd16;
  localparam logic [CFG_W-1:0] OLD_START_RST = 7'd48;

  typedef struct packed {
    logic [REFS_W-1:0] refs;
    logic [OFF_W-1:0]  offset;
    logic [FILE_W-1:0] file_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/fbr_ram.sv
// fbr_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module fbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fbr_block_cache_replacement_unit.sv
// fbr_block_cache_replacement_unit: frequency-based replacement tag store, top level
// depends on fbr_pkg and fbr_ram
//
// usage
//   s_axis carries one access per beat: the key (file id, block offset).
//   m_axis returns one result beat per access: hit flag, position before the
//   move, eviction flag and the evicted key.
//   cfg_we_i/cfg_idx_i/cfg_data_i write capacity, new section size and old
//   section start; write only while the block is idle.
// timing
//   one access at a time; s_axis_tready is high only between accesses.
//   the entries live in a ram in recency order and every step (tag search,
//   move to front, victim search, gap close) walks it one position a cycle
//   through its single read port.
// reset
//   rst_ni clears the entry count and loads the register defaults; ram
//   contents are not cleared, no entry beyond the count is ever read.
// stall
//   the result sits in an output register; the next access is accepted
//   while it waits, and that access holds in its last step until it drains.
module fbr_block_cache_replacement_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // fields from bit 0: file_id[15:0], block_offset[31:0]
  input  logic [fbr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // fields from bit 0: hit, hit_position[5:0], evicted, evicted_file_id[15:0],
  // evicted_offset[31:0]
  output logic [fbr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [fbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fbr_pkg::CFG_W-1:0]       cfg_data_i
);
  import fbr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_FRONT  = 3'd3;
  localparam logic [2:0] ST_EVSEL  = 3'd4;
  localparam logic [2:0] ST_DROP   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic             rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0] rd_pos_q, rd_pos_d;
  logic [FILE_W-1:0] key_file_q, key_file_d;
  logic [OFF_W-1:0]  key_off_q, key_off_d;
  logic             hit_q, hit_d;
  logic             ev_q, ev_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  entry_t           mov_q, mov_d;
  entry_t           best_q, best_d;
  logic [CNT_W-1:0] vic_q, vic_d;
  logic             bv_q, bv_d;

  logic [CFG_W-1:0] cap_q, nss_q, oss_q;

  logic                   out_vld_q, out_load;
  logic                   out_hit_q, out_ev_q;
  logic [HIT_POS_W-1:0]   out_pos_q;
  logic [FILE_W-1:0]      out_file_q;
  logic [OFF_W-1:0]       out_off_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_entry;

  logic [CMP_W-1:0] cap_eff;
  logic [CNT_W-1:0] cnt_new;
  logic             key_match, take;
  logic [CNT_W-1:0] vic_nx;

  fbr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign key_match = (rd_entry.file_id == key_file_q) && (rd_entry.offset == key_off_q);
  assign cnt_new   = cnt_q + 1'b1;

  // zero acts as one, anything above the store size acts as the store size
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_q);
    end
  end

  // later position wins a tie
  assign take   = !bv_q || (rd_entry.refs <= best_q.refs);
  assign vic_nx = take ? rd_pos_q : vic_q;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    rd_pos_d   = rd_pos_q;
    key_file_d = key_file_q;
    key_off_d  = key_off_q;
    hit_d      = hit_q;
    ev_d       = ev_q;
    pos_d      = pos_q;
    mov_d      = mov_q;
    best_d     = best_q;
    vic_d      = vic_q;
    bv_d       = bv_q;
    ram_re     = 1'b0;
    ram_raddr  = ADDR_W'(iss_q);
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_file_d = s_axis_tdata[FILE_W-1:0];
          key_off_d  = s_axis_tdata[FILE_W+OFF_W-1:FILE_W];
          hit_d      = 1'b0;
          ev_d       = 1'b0;
          pos_d      = '0;
          iss_d      = '0;
          if (cnt_q == '0) begin
            mov_d.refs    = REFS_W'(1);
            mov_d.offset  = s_axis_tdata[FILE_W+OFF_W-1:FILE_W];
            mov_d.file_id = s_axis_tdata[FILE_W-1:0];
            state_d       = ST_FRONT;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (iss_q < cnt_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_pos_d = iss_q;
          iss_d    = iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (key_match) begin
            hit_d = 1'b1;
            pos_d = rd_pos_q;
            mov_d = rd_entry;
            if ((CMP_W'(rd_pos_q) >= CMP_W'(nss_q)) && (rd_entry.refs != REFS_MAX)) begin
              mov_d.refs = rd_entry.refs + 1'b1;
            end
            rd_vld_d = 1'b0;
            iss_d    = rd_pos_q;
            state_d  = (rd_pos_q == '0) ? ST_FRONT : ST_SHIFT;
          end else if (rd_pos_q == cnt_q - 1'b1) begin
            mov_d.refs    = REFS_W'(1);
            mov_d.offset  = key_off_q;
            mov_d.file_id = key_file_q;
            rd_vld_d      = 1'b0;
            iss_d         = cnt_q;
            state_d       = ST_SHIFT;
          end
        end
      end

      // move the positions ahead of the moved entry one place back, last first
      ST_SHIFT: begin
        if (iss_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(iss_q - 1'b1);
          rd_vld_d  = 1'b1;
          rd_pos_d  = iss_q - 1'b1;
          iss_d     = iss_q - 1'b1;
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(rd_pos_q + 1'b1);
          ram_wdata = ram_rdata;
          if (rd_pos_q == '0) begin
            state_d = ST_FRONT;
          end
        end
      end

      ST_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = mov_q;
        if (hit_q) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_new;
          if (CMP_W'(cnt_new) > cap_eff) begin
            bv_d    = 1'b0;
            iss_d   = (CMP_W'(oss_q) >= CMP_W'(cnt_new)) ? cnt_q : CNT_W'(oss_q);
            state_d = ST_EVSEL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_EVSEL: begin
        if (iss_q < cnt_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_pos_d = iss_q;
          iss_d    = iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (take) begin
            best_d = rd_entry;
            vic_d  = rd_pos_q;
            bv_d   = 1'b1;
          end
          if (rd_pos_q == cnt_q - 1'b1) begin
            ev_d     = 1'b1;
            rd_vld_d = 1'b0;
            if (vic_nx == cnt_q - 1'b1) begin
              cnt_d   = cnt_q - 1'b1;
              state_d = ST_DONE;
            end else begin
              iss_d   = vic_nx + 1'b1;
              state_d = ST_DROP;
            end
          end
        end
      end

      // close the gap left by the victim
      ST_DROP: begin
        if (iss_q < cnt_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_pos_d = iss_q;
          iss_d    = iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(rd_pos_q - 1'b1);
          ram_wdata = ram_rdata;
          if (rd_pos_q == cnt_q - 1'b1) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cap_q     <= CAPACITY_RST;
      nss_q     <= NEW_SIZE_RST;
      oss_q     <= OLD_START_RST;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAPACITY:  cap_q <= cfg_data_i;
          REG_NEW_SIZE:  nss_q <= cfg_data_i;
          REG_OLD_START: oss_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q      <= iss_d;
    rd_pos_q   <= rd_pos_d;
    key_file_q <= key_file_d;
    key_off_q  <= key_off_d;
    hit_q      <= hit_d;
    ev_q       <= ev_d;
    pos_q      <= pos_d;
    mov_q      <= mov_d;
    best_q     <= best_d;
    vic_q      <= vic_d;
    bv_q       <= bv_d;
    if (out_load) begin
      out_hit_q  <= hit_q;
      out_pos_q  <= hit_q ? HIT_POS_W'(pos_q) : '0;
      out_ev_q   <= ev_q;
      out_file_q <= ev_q ? best_q.file_id : '0;
      out_off_q  <= ev_q ? best_q.offset : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_off_q, out_file_q, out_ev_q, out_pos_q, out_hit_q});

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (CMP_W'(cnt_q) <= CMP_W'(MAX_ENTRIES)))
    else $error("entry count above store size between accesses");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("entry ram read and written at one address");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q == ST_DONE))
    else $error("result loaded outside the done step");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> ((cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
                              (cnt_q + 1'b1 == $past(cnt_q))))
    else $error("entry count moved by more than one");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_hit_q && out_ev_q))
    else $error("result flags both a hit and an eviction");
`endif

endmodule

FILE: tb/sv/fbr_block_cache_replacement_unit_test.sv
// testbench for fbr_block_cache_replacement_unit: streams block keys in, checks every
// result beat against an in-bench copy of the replacement list and its policy registers
// depends on fbr_pkg and the block's rtl
module fbr_block_cache_replacement_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbr_pkg::*;

  localparam int IN_W        = IN_TDATA_W;
  localparam int OUT_W       = OUT_TDATA_W;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [FILE_W-1:0] file_id;
  } access_t;

  typedef struct packed {
    logic [OFF_W-1:0]     evicted_offset;
    logic [FILE_W-1:0]    evicted_file_id;
    logic                 evicted;
    logic [HIT_POS_W-1:0] hit_position;
    logic                 hit;
  } result_t;

  typedef struct {
    logic [FILE_W-1:0] file_id;
    logic [OFF_W-1:0]  offset;
    logic [REFS_W-1:0] refs;
  } line_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  // recency list as the block should hold it, position 0 most recent
  line_t             lines[SLOTS];
  int unsigned       line_cnt;
  logic [CFG_W-1:0]  pol_capacity;
  logic [CFG_W-1:0]  pol_new_size;
  logic [CFG_W-1:0]  pol_old_start;

  access_t           access_q[$];
  result_t           outcome_q[$];

  int                error_cnt = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_req = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                quiet_cycles = 0;
  bit                in_taken = 1'b0;

  fbr_block_cache_replacement_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  // search, promote or insert, and pick a victim; queues the result this access gives
  function automatic void apply_access(input access_t a);
    int unsigned cap_eff;
    int unsigned pos;
    int unsigned victim;
    bit          found;
    line_t       tmp;
    result_t     res;
    cap_eff = 32'(pol_capacity);
    if (cap_eff < 1) cap_eff = 1;
    if (cap_eff > MAX_ENTRIES) cap_eff = MAX_ENTRIES;
    res = '0;
    found = 1'b0;
    pos = 0;
    for (int unsigned i = 0; i < line_cnt; i++) begin
      if (!found && lines[i].file_id == a.file_id && lines[i].offset == a.offset) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      if (pos >= pol_new_size && lines[pos].refs != REFS_MAX) lines[pos].refs++;
      tmp = lines[pos];
      for (int unsigned k = pos; k > 0; k--) lines[k] = lines[k-1];
      lines[0] = tmp;
      res.hit = 1'b1;
      res.hit_position = pos[HIT_POS_W-1:0];
    end else begin
      for (int unsigned k = line_cnt; k > 0; k--) lines[k] = lines[k-1];
      lines[0].file_id = a.file_id;
      lines[0].offset = a.offset;
      lines[0].refs = REFS_W'(1);
      line_cnt++;
      if (line_cnt > cap_eff) begin
        victim = 32'(pol_old_start);
        if (victim >= line_cnt) victim = line_cnt - 1;
        // ties go to the later position
        for (int unsigned i = victim + 1; i < line_cnt; i++) begin
          if (lines[i].refs <= lines[victim].refs) victim = i;
        end
        res.evicted = 1'b1;
        res.evicted_file_id = lines[victim].file_id;
        res.evicted_offset = lines[victim].offset;
        for (int unsigned k = victim; k + 1 < line_cnt; k++) lines[k] = lines[k+1];
        line_cnt--;
      end
    end
    outcome_q.push_back(res);
  endfunction

  function automatic void queue_access(input logic [FILE_W-1:0] f, input logic [OFF_W-1:0] o);
    access_t a;
    a.file_id = f;
    a.offset = o;
    access_q.push_back(a);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CAPACITY: begin
        pol_capacity = value[CFG_W-1:0];
      end
      REG_NEW_SIZE: begin
        pol_new_size = value[CFG_W-1:0];
      end
      REG_OLD_START: begin
        pol_old_start = value[CFG_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_policy(input int cap, input int nsz, input int ost);
    cfg_write(REG_CAPACITY, cap);
    cfg_write(REG_NEW_SIZE, nsz);
    cfg_write(REG_OLD_START, ost);
  endtask

  // every access gives a result, so an empty outcome queue means the block is idle
  task automatic wait_drained();
    while (access_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // mostly reuse of a key pool sized near the capacity, the rest near misses and noise
  task automatic run_random_phase(input int cap, input int nsz, input int ost, input int n,
                                  input bit long_hold);
    access_t pool[$];
    access_t a;
    int      eff;
    int      psize;
    int      r;
    set_policy(cap, nsz, ost);
    eff = (cap < 1) ? 1 : ((cap > MAX_ENTRIES) ? MAX_ENTRIES : cap);
    psize = eff + $urandom_range(1, eff / 2 + 3);
    repeat (psize) begin
      a.file_id = FILE_W'($urandom);
      a.offset = $urandom;
      pool.push_back(a);
    end
    repeat (n) begin
      r = $urandom_range(0, 99);
      a = pool[$urandom_range(0, pool.size() - 1)];
      if (r >= 94) begin
        a.file_id = FILE_W'($urandom);
        a.offset = $urandom;
      end else if (r >= 88) begin
        a.file_id = FILE_W'($urandom);
      end else if (r >= 80) begin
        a.offset = $urandom;
      end
      access_q.push_back(a);
    end
    if (long_hold) hold_req++;
    wait_drained();
  endtask

  // sender: offers the next pending key, holds it until the beat is taken
  always @(negedge clk_i) begin : drive_access
    logic [IN_W-1:0] word;
    word = '0;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        word[$bits(access_t)-1:0] = access_q.pop_front();
        s_axis_tdata <= word;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random ready, with a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watch_beats
    result_t got;
    result_t want;
    access_t a;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with no access outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
          if (got.hit_position !== want.hit_position)
            report_mismatch($sformatf("hit_position got %0d want %0d",
                                      got.hit_position, want.hit_position));
          if (got.evicted !== want.evicted)
            report_mismatch($sformatf("evicted got %0b want %0b", got.evicted, want.evicted));
          if (got.evicted_file_id !== want.evicted_file_id)
            report_mismatch($sformatf("evicted_file_id got %h want %h",
                                      got.evicted_file_id, want.evicted_file_id));
          if (got.evicted_offset !== want.evicted_offset)
            report_mismatch($sformatf("evicted_offset got %h want %h",
                                      got.evicted_offset, want.evicted_offset));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        a = s_axis_tdata[$bits(access_t)-1:0];
        apply_access(a);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("fbr_block_cache_replacement_unit_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    access_t a;
    line_cnt = 0;
    pol_capacity = CAPACITY_RST;
    pol_new_size = NEW_SIZE_RST;
    pol_old_start = OLD_START_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 78;

    // reset policy: extremes of the key fields, hits inside the new section
    queue_access(16'h0000, 32'h0000_0000);
    queue_access(16'hFFFF, 32'hFFFF_FFFF);
    queue_access(16'h0000, 32'h0000_0000);
    queue_access(16'hFFFF, 32'hFFFF_FFFF);
    queue_access(16'h0000, 32'hFFFF_FFFF);
    queue_access(16'hFFFF, 32'h0000_0000);
    queue_access(16'h0000, 32'h0000_0000);
    queue_access(16'h0000, 32'h0000_0000);
    wait_drained();

    // zero capacity acts as one, every hit counts
    set_policy(0, 0, 0);
    queue_access(16'h0001, 32'h0000_0001);
    queue_access(16'h0001, 32'h0000_0001);
    queue_access(16'h0002, 32'h0000_0002);
    wait_drained();

    // old section past the end of the list: last entry goes
    cfg_write(REG_OLD_START, 127);
    queue_access(16'h0003, 32'h0000_0003);
    queue_access(16'h0001, 32'h0000_0001);
    wait_drained();

    // capacity below the fill, count raised only past the new section
    set_policy(3, 1, 1);
    queue_access(16'hAAAA, 32'h5555_5555);
    queue_access(16'h5555, 32'hAAAA_AAAA);
    queue_access(16'hAAAA, 32'h5555_5555);
    queue_access(16'h5555, 32'hAAAA_AAAA);
    queue_access(16'h1234, 32'h89AB_CDEF);
    queue_access(16'hAAAA, 32'h5555_5555);
    wait_drained();

    // capacity above the maximum acts as the maximum
    set_policy(127, 64, 64);
    queue_access(16'h0002, 32'h0000_0002);
    queue_access(16'h8000, 32'h8000_0000);
    queue_access(16'h0001, 32'h0000_0001);
    wait_drained();

    // list never shrinks, so capacities mostly climb from here
    run_random_phase(2, 0, 0, 60, 1'b0);
    run_random_phase(8, 3, 5, 60, 1'b1);
    run_random_phase(16, 16, 127, 60, 1'b0);

    send_idle_pct = 78;
    recv_idle_pct = 26;
    run_random_phase(1, 127, 64, 60, 1'b0);
    run_random_phase(32, $urandom_range(0, 64), $urandom_range(0, 64), 60, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(64, 64, 63, 60, 1'b0);
    run_random_phase(127, 0, 0, 60, 1'b0);
    run_random_phase($urandom_range(1, 64), $urandom_range(0, 64), $urandom_range(0, 64), 60,
                     1'b0);

    // repeat one key at position 0 with every hit counting, then misses around it
    set_policy(64, 0, 0);
    a.file_id = 16'h5A5A;
    a.offset = 32'hA5A5_A5A5;
    repeat (10) access_q.push_back(a);
    repeat (6) queue_access(FILE_W'($urandom), $urandom);
    access_q.push_back(a);
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
    if (error_cnt == 0)
      $display("fbr_block_cache_replacement_unit_test OK");
    else
      $display("fbr_block_cache_replacement_unit_test NOT OK");
    $finish;
  end

endmodule
